// ===== design/mps_pkg.sv =====
`default_nettype none

package mps_pkg;

    // Default sizes of the block.
    localparam int CHANNELS_DEF      = 4;
    localparam int ENTRIES_DEF       = 256;
    localparam int DURATION_BITS_DEF = 16;

    // Fixed field widths.
    localparam int OP_W       = 2;
    localparam int SEL_W      = 2;
    localparam int INDEX_W    = 8;
    localparam int DUR_IN_W   = 16;
    localparam int MASK_W     = 4;
    localparam int LEN_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // Stream widths.
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 8;

    // Only the first four channels have a length register, a repeat bit
    // and a place in the result.
    localparam int NUM_LEN_REGS = 4;
    localparam int LEN_SEL_W    = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_LAST  = 3'd4;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_START = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

endpackage

`default_nettype wire

// ===== design/multichannel_pattern_sequencer.sv =====
`default_nettype none

// Multichannel pattern sequencer: each channel plays a list of (duration,
// level) entries from a shared entry memory, one list of ENTRIES per channel.
// Items arrive on the s_ stream: s_tuser carries the operation (timer tick,
// entry write, channel start, or no operation) and s_tdata its operands.
// Every item returns exactly one result on the m_ stream with the levels and
// running flags of the first four channels after the item is applied.
// List lengths and the repeat mask are set over the cfg_ write port, which is
// always ready; the user must see that it is written only while no item is in
// flight (the block does not enforce this). A tick occupies the issue stage
// while it walks the channels, one per cycle when not stalled, as each channel
// needs its own pair of reads (current and next entry) from the two read ports
// of the entry memory; every other item issues once. After an item's last
// issue, its result passes the update stage and output register. A tick waits
// while the update stage holds a start or a tick of its channel. After reset
// all channels are stopped at level zero; the entry memory is not cleared and
// holds garbage until written. When the receiver stalls, the result waits in
// the output register, the item behind it can hold in the update stage, and
// one more item can be accepted into the issue stage; further items then wait.

module multichannel_pattern_sequencer
    import mps_pkg::*;
#(
    parameter int CHANNELS      = CHANNELS_DEF,
    parameter int ENTRIES       = ENTRIES_DEF,
    parameter int DURATION_BITS = DURATION_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input items.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // s_tdata, from bit 0: channel[1:0], entry_index[9:2],
    // entry_duration[25:10], entry_level[26], start_mask[30:27], zero[31]
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser, from bit 0: op[1:0]
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    // Result items.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // m_tdata, from bit 0: channel_levels[3:0], channels_running[7:4]
    output logic      [M_TDATA_W-1:0]  m_tdata,
    // Configuration writes.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW    = $clog2(ENTRIES + 1);
    localparam int LW    = (PW > LEN_W) ? PW : LEN_W;
    localparam int DEPTH = CHANNELS * ENTRIES;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = DURATION_BITS + 1;
    localparam int VIS   = (CHANNELS < NUM_LEN_REGS) ? CHANNELS : NUM_LEN_REGS;

    // Configuration registers.
    logic [MASK_W-1:0] repeat_mask_reg;
    logic [LEN_W-1:0]  list_len_reg [NUM_LEN_REGS];
    logic [LEN_SEL_W-1:0] len_sel;

    // Per-channel playback state.
    logic [PW-1:0]            pos_reg    [CHANNELS];
    logic [PW-1:0]            pos_next   [CHANNELS];
    logic [DURATION_BITS-1:0] cnt_reg    [CHANNELS];
    logic [DURATION_BITS-1:0] cnt_next   [CHANNELS];
    logic                     active_reg [CHANNELS];
    logic                     active_next[CHANNELS];
    logic                     level_reg  [CHANNELS];
    logic                     level_next [CHANNELS];

    // Issue stage.
    logic                 i_valid_reg, i_valid_next;
    op_t                  i_op_reg;
    logic [CW-1:0]        i_ch_reg, i_ch_next;
    logic [SEL_W-1:0]     i_wch_reg;
    logic [INDEX_W-1:0]   i_idx_reg;
    logic [DUR_IN_W-1:0]  i_dur_reg;
    logic                 i_lvl_reg;
    logic [MASK_W-1:0]    i_mask_reg;
    logic                 i_tick, i_last, i_fire, hazard, s_accept;

    // Update stage.
    logic                 p_valid_reg;
    op_t                  p_op_reg;
    logic [CW-1:0]        p_ch_reg;
    logic                 p_last_reg;
    logic [PW-1:0]        p_pos_reg;
    logic [MASK_W-1:0]    p_mask_reg;

    // Output register.
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;
    logic                 adv;

    // Entry memory.
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [MW-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;

    // Per-channel views of the configuration and of the start mask.
    logic [LW-1:0] chan_len [CHANNELS];
    logic          chan_rep [CHANNELS];
    logic          start_vec[CHANNELS];

    // Update stage working signals.
    logic [LW-1:0]            len_eff;
    logic [PW-1:0]            pos_inc;
    logic                     in_list;
    logic [DURATION_BITS-1:0] dur_a;
    logic                     lvl_b;

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            chan_len[c]  = '0;
            chan_rep[c]  = 1'b0;
            start_vec[c] = 1'b0;
        end
        for (int c = 0; c < VIS; c++) begin
            chan_len[c]  = LW'(list_len_reg[c]);
            chan_rep[c]  = repeat_mask_reg[c];
            start_vec[c] = p_mask_reg[c];
        end
    end

    //--------------------------------------------------------------------
    // Issue stage: a tick walks the channels, reading the current and the
    // next entry of each; an entry write goes to memory here so that a tick
    // issued in the next cycle already sees it.
    //--------------------------------------------------------------------
    assign adv    = !out_valid_reg || m_tready;
    assign i_tick = (i_op_reg == OP_TICK);
    assign i_last = !i_tick || (i_ch_reg == CW'(CHANNELS - 1));

    // The update stage still owns the channel about to be read.
    assign hazard = p_valid_reg && i_tick &&
                    (((p_op_reg == OP_TICK) && (p_ch_reg == i_ch_reg)) ||
                     ((p_op_reg == OP_START) && start_vec[i_ch_reg]));

    assign i_fire   = i_valid_reg && adv && !hazard;
    assign s_tready = !i_valid_reg || (i_fire && i_last);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        i_valid_next = i_valid_reg;
        i_ch_next    = i_ch_reg;
        if (s_accept) begin
            i_valid_next = 1'b1;
            i_ch_next    = '0;
        end else if (i_fire) begin
            if (i_last) begin
                i_valid_next = 1'b0;
            end else begin
                i_ch_next = i_ch_reg + 1'b1;
            end
        end
    end

    assign ram_re      = i_fire && i_tick;
    assign ram_raddr_a = AW'(AW'(i_ch_reg) * AW'(ENTRIES)) + AW'(pos_reg[i_ch_reg]);
    assign ram_raddr_b = ram_raddr_a + AW'(1);

    assign ram_we    = i_fire && (i_op_reg == OP_WRITE) &&
                       (32'(i_wch_reg) < 32'(CHANNELS)) &&
                       (32'(i_idx_reg) < 32'(ENTRIES));
    assign ram_waddr = AW'(AW'(i_wch_reg) * AW'(ENTRIES)) + AW'(i_idx_reg);
    assign ram_wdata = {i_lvl_reg, DURATION_BITS'(i_dur_reg)};

    mps_ram #(
        .WIDTH (MW),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    //--------------------------------------------------------------------
    // Update stage: applies one channel of a tick, or a start, and forms
    // the result on the last cycle of an item.
    //--------------------------------------------------------------------
    assign dur_a   = ram_rdata_a[DURATION_BITS-1:0];
    assign lvl_b   = ram_rdata_b[DURATION_BITS];
    assign len_eff = (chan_len[p_ch_reg] > LW'(ENTRIES)) ? LW'(ENTRIES)
                                                         : chan_len[p_ch_reg];
    assign pos_inc = p_pos_reg + 1'b1;
    assign in_list = (LW'(p_pos_reg) < len_eff);

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            pos_next[c]    = pos_reg[c];
            cnt_next[c]    = cnt_reg[c];
            active_next[c] = active_reg[c];
            level_next[c]  = level_reg[c];
        end
        if (p_valid_reg && adv) begin
            case (p_op_reg)
                OP_TICK: begin
                    if (active_reg[p_ch_reg]) begin
                        if (in_list) begin
                            if (cnt_reg[p_ch_reg] != dur_a) begin
                                cnt_next[p_ch_reg] = cnt_reg[p_ch_reg] + 1'b1;
                            end else begin
                                // Entry held long enough: move on and take
                                // the level of the new entry if it exists.
                                cnt_next[p_ch_reg] = '0;
                                pos_next[p_ch_reg] = pos_inc;
                                if (LW'(pos_inc) < len_eff) begin
                                    level_next[p_ch_reg] = lvl_b;
                                end
                            end
                        end else if (chan_rep[p_ch_reg]) begin
                            pos_next[p_ch_reg] = '0;
                        end else begin
                            active_next[p_ch_reg] = 1'b0;
                        end
                    end
                end
                OP_START: begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (start_vec[c]) begin
                            active_next[c] = 1'b1;
                            pos_next[c]    = '0;
                            cnt_next[c]    = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        out_data_next = '0;
        for (int c = 0; c < VIS; c++) begin
            out_data_next[c]          = level_next[c];
            out_data_next[MASK_W + c] = active_next[c];
        end
    end

    //--------------------------------------------------------------------
    // Registers.
    //--------------------------------------------------------------------
    assign len_sel = LEN_SEL_W'(cfg_index - CFG_LEN_FIRST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repeat_mask_reg <= '0;
            for (int r = 0; r < NUM_LEN_REGS; r++) begin
                list_len_reg[r] <= '0;
            end
        end else if (cfg_valid) begin
            if (cfg_index == CFG_REPEAT) begin
                repeat_mask_reg <= cfg_data[MASK_W-1:0];
            end else if (cfg_index inside {[CFG_LEN_FIRST:CFG_LEN_LAST]}) begin
                list_len_reg[len_sel] <= cfg_data[LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                pos_reg[c]    <= '0;
                cnt_reg[c]    <= '0;
                active_reg[c] <= 1'b0;
                level_reg[c]  <= 1'b0;
            end
        end else begin
            for (int c = 0; c < CHANNELS; c++) begin
                pos_reg[c]    <= pos_next[c];
                cnt_reg[c]    <= cnt_next[c];
                active_reg[c] <= active_next[c];
                level_reg[c]  <= level_next[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_valid_reg   <= 1'b0;
            i_ch_reg      <= '0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            i_valid_reg <= i_valid_next;
            i_ch_reg    <= i_ch_next;
            if (adv) begin
                p_valid_reg <= i_fire;
            end
            if (p_valid_reg && p_last_reg && adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            i_op_reg   <= op_t'(s_tuser[OP_W-1:0]);
            i_wch_reg  <= s_tdata[1:0];
            i_idx_reg  <= s_tdata[9:2];
            i_dur_reg  <= s_tdata[25:10];
            i_lvl_reg  <= s_tdata[26];
            i_mask_reg <= s_tdata[30:27];
        end
        if (i_fire) begin
            p_op_reg   <= i_op_reg;
            p_ch_reg   <= i_ch_reg;
            p_last_reg <= i_last;
            p_pos_reg  <= pos_reg[i_ch_reg];
            p_mask_reg <= i_mask_reg;
        end
        if (p_valid_reg && p_last_reg && adv) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== design/mps_ram.sv =====
`default_nettype none

module mps_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire
